@@ hw/rtl/pbwt_pkg.sv @@
// ----------------------------------------------------------------------------
// pbwt_pkg
// Shared types and codes for the protobuf wire-format tokenizer
// ----------------------------------------------------------------------------
package pbwt_pkg;

    // decoder phase
    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_F32     = 3'd2,
        PH_F64     = 3'd3,
        PH_LEN     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DROP    = 3'd6
    } phase_t;

    // token kinds
    localparam logic [2:0] TK_TAG    = 3'd0;
    localparam logic [2:0] TK_VARINT = 3'd1;
    localparam logic [2:0] TK_F32    = 3'd2;
    localparam logic [2:0] TK_F64    = 3'd3;
    localparam logic [2:0] TK_LEN    = 3'd4;
    localparam logic [2:0] TK_BYTE   = 3'd5;
    localparam logic [2:0] TK_ERR    = 3'd6;

    // error codes
    localparam logic [2:0] ERR_TRUNC_VARINT = 3'd0;
    localparam logic [2:0] ERR_VARINT_LONG  = 3'd1;
    localparam logic [2:0] ERR_PAST_END     = 3'd2;
    localparam logic [2:0] ERR_TRUNC_F32    = 3'd3;
    localparam logic [2:0] ERR_TRUNC_F64    = 3'd4;
    localparam logic [2:0] ERR_BAD_WIRE     = 3'd5;
    localparam logic [2:0] ERR_NONE         = 3'd0;

    // wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    // varint limits
    localparam logic [3:0] VARINT_LAST_IDX = 4'd9;
    localparam logic [6:0] VARINT_MAX_SHIFT = 7'd63;
    localparam logic [3:0] F32_BYTES = 4'd4;
    localparam logic [3:0] F64_BYTES = 4'd8;

endpackage

@@ hw/rtl/protobuf_wire_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// protobuf_wire_tokenizer_top
// Streaming protocol buffers wire-format tokenizer, one message byte per word
// ----------------------------------------------------------------------------
// Takes an encoded message one byte per word, with end_of_message on the final
// byte, and gives at most one token per byte: tag, varint, fixed32, fixed64,
// length, payload byte or error. A byte is taken every clock cycle; the token
// it causes appears on the m_ side in the following cycle, held in a single
// output register. s_ready is low only while that register holds a token that
// m_ready does not take, so the one-byte-per-cycle rate is set by the output
// register and its drain. After an error the rest of the message is dropped
// silently up to and including its final byte.
// ----------------------------------------------------------------------------
module protobuf_wire_tokenizer_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_message,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_token_kind,
    output logic [31:0] m_field_number,
    output logic [2:0]  m_wire_type,
    output logic [63:0] m_token_value,
    output logic [2:0]  m_error_code,
    output logic        m_last_of_message
);

    // decoder state
    pbwt_pkg::phase_t phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  count_reg, count_next;
    logic [63:0] remain_reg, remain_next;
    logic [31:0] field_reg, field_next;
    logic [2:0]  wire_reg, wire_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [31:0] ofield_reg, ofield_next;
    logic [2:0]  owire_reg, owire_next;
    logic [63:0] value_reg, value_next;
    logic [2:0]  err_reg, err_next;
    logic        last_reg, last_next;

    logic        accept;
    logic        last_in;

    // per-byte helpers
    logic [6:0]  vshift;
    logic [63:0] vacc;
    logic        vdone;
    logic        vlong;
    logic [63:0] facc;
    logic [3:0]  count_inc;
    logic [63:0] remain_dec;

    // result of the byte decode
    logic        emit;
    logic [2:0]  emit_kind;
    logic [63:0] emit_value;
    logic        fail;
    logic [2:0]  fail_code;
    logic        go_tag;

    assign accept  = s_valid && s_ready;
    assign s_ready = !out_valid_reg || m_ready;
    assign last_in = s_end_of_message;

    // varint byte: 7 payload bits at 7*count, bits above 63 dropped
    assign vshift = 7'(count_reg) * 7'd7;
    assign vacc   = acc_reg | ((vshift <= pbwt_pkg::VARINT_MAX_SHIFT)
                    ? ({57'd0, s_data_byte[6:0]} << vshift[5:0]) : 64'd0);
    assign vdone  = !s_data_byte[7];
    assign vlong  = s_data_byte[7] && (count_reg >= pbwt_pkg::VARINT_LAST_IDX);

    // fixed byte: little-endian placement
    assign facc       = acc_reg | ({56'd0, s_data_byte} << {count_reg[2:0], 3'b000});
    assign count_inc  = count_reg + 4'd1;
    assign remain_dec = remain_reg - 64'd1;

    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        field_next  = field_reg;
        wire_next   = wire_reg;
        emit        = 1'b0;
        emit_kind   = pbwt_pkg::TK_TAG;
        emit_value  = 64'd0;
        fail        = 1'b0;
        fail_code   = pbwt_pkg::ERR_NONE;
        go_tag      = 1'b0;

        case (phase_reg)
            pbwt_pkg::PH_TAG, pbwt_pkg::PH_VARINT, pbwt_pkg::PH_LEN: begin
                acc_next = vacc;
                if (vlong) begin
                    fail      = 1'b1;
                    fail_code = pbwt_pkg::ERR_VARINT_LONG;
                end else if (!vdone) begin
                    count_next = count_inc;
                    if (last_in) begin
                        fail      = 1'b1;
                        fail_code = pbwt_pkg::ERR_TRUNC_VARINT;
                    end
                end else if (phase_reg == pbwt_pkg::PH_TAG) begin
                    // tag complete: latch field and wire type
                    field_next = vacc[34:3];
                    wire_next  = vacc[2:0];
                    acc_next   = 64'd0;
                    count_next = 4'd0;
                    if (!(vacc[2:0] inside {pbwt_pkg::WT_VARINT, pbwt_pkg::WT_I64,
                                             pbwt_pkg::WT_LEN, pbwt_pkg::WT_I32})) begin
                        fail      = 1'b1;
                        fail_code = pbwt_pkg::ERR_BAD_WIRE;
                    end else if (last_in) begin
                        // tag on final byte: truncation of what should follow
                        fail = 1'b1;
                        case (vacc[2:0])
                            pbwt_pkg::WT_I64: fail_code = pbwt_pkg::ERR_TRUNC_F64;
                            pbwt_pkg::WT_I32: fail_code = pbwt_pkg::ERR_TRUNC_F32;
                            default:          fail_code = pbwt_pkg::ERR_TRUNC_VARINT;
                        endcase
                    end else begin
                        emit       = 1'b1;
                        emit_kind  = pbwt_pkg::TK_TAG;
                        emit_value = vacc;
                        case (vacc[2:0])
                            pbwt_pkg::WT_VARINT: phase_next = pbwt_pkg::PH_VARINT;
                            pbwt_pkg::WT_I64:    phase_next = pbwt_pkg::PH_F64;
                            pbwt_pkg::WT_I32:    phase_next = pbwt_pkg::PH_F32;
                            default:             phase_next = pbwt_pkg::PH_LEN;
                        endcase
                    end
                end else if (phase_reg == pbwt_pkg::PH_VARINT) begin
                    emit       = 1'b1;
                    emit_kind  = pbwt_pkg::TK_VARINT;
                    emit_value = vacc;
                    go_tag     = 1'b1;
                end else if ((vacc != 64'd0) && last_in) begin
                    fail      = 1'b1;
                    fail_code = pbwt_pkg::ERR_PAST_END;
                end else begin
                    emit       = 1'b1;
                    emit_kind  = pbwt_pkg::TK_LEN;
                    emit_value = vacc;
                    if (vacc == 64'd0) begin
                        go_tag = 1'b1;
                    end else begin
                        acc_next    = 64'd0;
                        count_next  = 4'd0;
                        remain_next = vacc;
                        phase_next  = pbwt_pkg::PH_PAYLOAD;
                    end
                end
            end
            pbwt_pkg::PH_F32, pbwt_pkg::PH_F64: begin
                acc_next   = facc;
                count_next = count_inc;
                if (count_inc >= ((phase_reg == pbwt_pkg::PH_F32)
                                  ? pbwt_pkg::F32_BYTES : pbwt_pkg::F64_BYTES)) begin
                    emit       = 1'b1;
                    emit_kind  = (phase_reg == pbwt_pkg::PH_F32)
                                 ? pbwt_pkg::TK_F32 : pbwt_pkg::TK_F64;
                    emit_value = facc;
                    go_tag     = 1'b1;
                end else if (last_in) begin
                    fail      = 1'b1;
                    fail_code = (phase_reg == pbwt_pkg::PH_F32)
                                ? pbwt_pkg::ERR_TRUNC_F32 : pbwt_pkg::ERR_TRUNC_F64;
                end
            end
            pbwt_pkg::PH_PAYLOAD: begin
                if ((remain_reg > 64'd1) && last_in) begin
                    fail      = 1'b1;
                    fail_code = pbwt_pkg::ERR_PAST_END;
                end else begin
                    emit        = 1'b1;
                    emit_kind   = pbwt_pkg::TK_BYTE;
                    emit_value  = {56'd0, s_data_byte};
                    remain_next = remain_dec;
                    if (remain_dec == 64'd0) begin
                        go_tag = 1'b1;
                    end
                end
            end
            pbwt_pkg::PH_DROP: begin
                if (last_in) begin
                    go_tag = 1'b1;
                end
            end
            default: begin
                go_tag = 1'b1;
            end
        endcase

        // error token replaces anything else; rest of message is dropped
        if (fail) begin
            emit       = 1'b1;
            emit_kind  = pbwt_pkg::TK_ERR;
            emit_value = 64'd0;
            if (last_in) begin
                go_tag = 1'b1;
            end else begin
                phase_next = pbwt_pkg::PH_DROP;
            end
        end

        // token fields carry field and wire type as left by this byte
        ofield_next = field_next;
        owire_next  = wire_next;
        kind_next   = emit_kind;
        value_next  = emit_value;
        err_next    = fail ? fail_code : pbwt_pkg::ERR_NONE;
        // a tag token never ends the message
        last_next   = last_in && !(emit_kind == pbwt_pkg::TK_TAG);

        if (go_tag) begin
            phase_next  = pbwt_pkg::PH_TAG;
            acc_next    = 64'd0;
            count_next  = 4'd0;
            remain_next = 64'd0;
            field_next  = 32'd0;
            wire_next   = 3'd0;
        end

        // output register: load on an emitting byte, else drain
        if (accept) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= pbwt_pkg::PH_TAG;
            acc_reg       <= 64'd0;
            count_reg     <= 4'd0;
            remain_reg    <= 64'd0;
            field_reg     <= 32'd0;
            wire_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                count_reg  <= count_next;
                remain_reg <= remain_next;
                field_reg  <= field_next;
                wire_reg   <= wire_next;
            end
        end
    end

    // token payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            kind_reg   <= kind_next;
            ofield_reg <= ofield_next;
            owire_reg  <= owire_next;
            value_reg  <= value_next;
            err_reg    <= err_next;
            last_reg   <= last_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_token_kind      = kind_reg;
    assign m_field_number    = ofield_reg;
    assign m_wire_type       = owire_reg;
    assign m_token_value     = value_reg;
    assign m_error_code      = err_reg;
    assign m_last_of_message = last_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the protobuf wire-format tokenizer
// ----------------------------------------------------------------------------
// Feeds encoded messages one byte per word and predicts every token with an
// independent software tokenizer. Tokens are checked in order as they leave
// the block. Directed messages cover each token kind and each error path;
// random messages (mostly well-formed, some truncated or corrupted) run under
// several idling mixes, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    // clock and reset
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    // input side, known from time zero
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte      = 8'd0;
    logic        s_end_of_message = 1'b0;

    // result side
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_token_kind;
    logic [31:0] m_field_number;
    logic [2:0]  m_wire_type;
    logic [63:0] m_token_value;
    logic [2:0]  m_error_code;
    logic        m_last_of_message;

    protobuf_wire_tokenizer_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_message  (s_end_of_message),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_token_kind      (m_token_kind),
        .m_field_number    (m_field_number),
        .m_wire_type       (m_wire_type),
        .m_token_value     (m_token_value),
        .m_error_code      (m_error_code),
        .m_last_of_message (m_last_of_message)
    );

    // 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // one token as it leaves the block
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] field;
        logic [2:0]  wtype;
        logic [63:0] value;
        logic [2:0]  err;
        logic        eom;
    } token_t;

    // outcome of one varint byte
    typedef enum logic [1:0] {
        VB_MORE,
        VB_DONE,
        VB_LONG
    } vbyte_t;

    token_t      expected_tokens[$];
    logic [7:0]  msg_q[$];
    int unsigned fail_count     = 0;
    int unsigned words_sent     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_off       = 0;

    // software copy of the tokenizer state
    pbwt_pkg::phase_t dec_phase;
    logic [63:0] dec_acc;
    logic [3:0]  dec_count;
    logic [63:0] dec_owed;
    logic [31:0] dec_field;
    logic [2:0]  dec_wtype;

    // ------------------------------------------------------------------------
    // token predictor
    // ------------------------------------------------------------------------

    function automatic logic known_wire(logic [2:0] wt);
        return wt inside {pbwt_pkg::WT_VARINT, pbwt_pkg::WT_I64,
                          pbwt_pkg::WT_LEN, pbwt_pkg::WT_I32};
    endfunction

    // back to waiting for a tag, all state cleared
    function automatic void clear_decoder();
        dec_phase = pbwt_pkg::PH_TAG;
        dec_acc   = 64'd0;
        dec_count = 4'd0;
        dec_owed  = 64'd0;
        dec_field = 32'd0;
        dec_wtype = 3'd0;
    endfunction

    // fold one varint byte into the accumulator, bits past 63 fall away
    function automatic vbyte_t absorb_varint(logic [7:0] b);
        logic [6:0] sh;
        sh = 7'(dec_count) * 7'd7;
        if (sh <= pbwt_pkg::VARINT_MAX_SHIFT) begin
            dec_acc = dec_acc | ({57'd0, b[6:0]} << sh);
        end
        if (!b[7]) begin
            return VB_DONE;
        end
        if (dec_count >= pbwt_pkg::VARINT_LAST_IDX) begin
            return VB_LONG;
        end
        dec_count = dec_count + 4'd1;
        return VB_MORE;
    endfunction

    // tokens carry the field and wire type of the tag in force
    function automatic void push_token(logic [2:0] kind, logic [63:0] value,
                                       logic [2:0] err, logic eom);
        token_t t;
        t = {kind, dec_field, dec_wtype, value, err, eom};
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    // an error ends the message, or drops the bytes up to its end
    function automatic void raise_error(logic [2:0] err, logic eom);
        push_token(pbwt_pkg::TK_ERR, 64'd0, err, eom);
        if (eom) begin
            clear_decoder();
        end else begin
            dec_phase = pbwt_pkg::PH_DROP;
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] b, logic eom);
        vbyte_t      vs;
        logic [63:0] v;
        logic [3:0]  need;
        case (dec_phase)
            pbwt_pkg::PH_TAG: begin
                vs = absorb_varint(b);
                if (vs == VB_LONG) begin
                    raise_error(pbwt_pkg::ERR_VARINT_LONG, eom);
                end else if (vs == VB_MORE) begin
                    if (eom) begin
                        raise_error(pbwt_pkg::ERR_TRUNC_VARINT, eom);
                    end
                end else begin
                    v         = dec_acc;
                    dec_field = v[34:3];
                    dec_wtype = v[2:0];
                    dec_acc   = 64'd0;
                    dec_count = 4'd0;
                    if (!known_wire(dec_wtype)) begin
                        raise_error(pbwt_pkg::ERR_BAD_WIRE, eom);
                    end else if (eom) begin
                        // tag on the final byte: report what should have followed
                        raise_error((dec_wtype == pbwt_pkg::WT_I64)
                                    ? pbwt_pkg::ERR_TRUNC_F64
                                    : (dec_wtype == pbwt_pkg::WT_I32)
                                    ? pbwt_pkg::ERR_TRUNC_F32
                                    : pbwt_pkg::ERR_TRUNC_VARINT, eom);
                    end else begin
                        case (dec_wtype)
                            pbwt_pkg::WT_VARINT: dec_phase = pbwt_pkg::PH_VARINT;
                            pbwt_pkg::WT_I64:    dec_phase = pbwt_pkg::PH_F64;
                            pbwt_pkg::WT_I32:    dec_phase = pbwt_pkg::PH_F32;
                            default:             dec_phase = pbwt_pkg::PH_LEN;
                        endcase
                        push_token(pbwt_pkg::TK_TAG, v, pbwt_pkg::ERR_NONE, 1'b0);
                    end
                end
            end
            pbwt_pkg::PH_VARINT, pbwt_pkg::PH_LEN: begin
                vs = absorb_varint(b);
                if (vs == VB_LONG) begin
                    raise_error(pbwt_pkg::ERR_VARINT_LONG, eom);
                end else if (vs == VB_MORE) begin
                    if (eom) begin
                        raise_error(pbwt_pkg::ERR_TRUNC_VARINT, eom);
                    end
                end else begin
                    v = dec_acc;
                    if (dec_phase == pbwt_pkg::PH_VARINT) begin
                        push_token(pbwt_pkg::TK_VARINT, v, pbwt_pkg::ERR_NONE, eom);
                        clear_decoder();
                    end else if (v != 64'd0 && eom) begin
                        raise_error(pbwt_pkg::ERR_PAST_END, eom);
                    end else begin
                        push_token(pbwt_pkg::TK_LEN, v, pbwt_pkg::ERR_NONE, eom);
                        if (v == 64'd0) begin
                            clear_decoder();
                        end else begin
                            dec_acc   = 64'd0;
                            dec_count = 4'd0;
                            dec_owed  = v;
                            dec_phase = pbwt_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            pbwt_pkg::PH_F32, pbwt_pkg::PH_F64: begin
                // little-endian assembly
                need      = (dec_phase == pbwt_pkg::PH_F32)
                            ? pbwt_pkg::F32_BYTES : pbwt_pkg::F64_BYTES;
                dec_acc   = dec_acc | ({56'd0, b} << {dec_count[2:0], 3'b000});
                dec_count = dec_count + 4'd1;
                if (dec_count >= need) begin
                    push_token((dec_phase == pbwt_pkg::PH_F32)
                               ? pbwt_pkg::TK_F32 : pbwt_pkg::TK_F64, dec_acc,
                               pbwt_pkg::ERR_NONE, eom);
                    clear_decoder();
                end else if (eom) begin
                    raise_error((dec_phase == pbwt_pkg::PH_F32)
                                ? pbwt_pkg::ERR_TRUNC_F32 : pbwt_pkg::ERR_TRUNC_F64, eom);
                end
            end
            pbwt_pkg::PH_PAYLOAD: begin
                if (dec_owed > 64'd1 && eom) begin
                    raise_error(pbwt_pkg::ERR_PAST_END, eom);
                end else begin
                    push_token(pbwt_pkg::TK_BYTE, {56'd0, b}, pbwt_pkg::ERR_NONE, eom);
                    dec_owed = dec_owed - 64'd1;
                    if (dec_owed == 64'd0) begin
                        clear_decoder();
                    end
                end
            end
            default: begin
                // dropping after an error until the final byte
                if (eom) begin
                    clear_decoder();
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // message building
    // ------------------------------------------------------------------------

    // one byte onto the end of the message
    function automatic void put_byte(logic [7:0] b);
        msg_q.insert(msg_q.size(), b);
    endfunction

    // varint, padded with redundant groups up to min_len bytes
    function automatic void put_varint(logic [63:0] v, int unsigned min_len);
        logic [63:0] rest;
        logic        more;
        int unsigned n;
        n = 0;
        do begin
            rest = v >> 7;
            n++;
            more = (rest != 64'd0) || (n < min_len);
            put_byte({more, v[6:0]});
            v = rest;
        end while (more);
    endfunction

    // tag varint, now and then with junk above bit 34
    function automatic void put_tag(logic [31:0] field, logic [2:0] wt, int unsigned min_len);
        logic [63:0] tag;
        tag = {29'd0, field, wt};
        if ($urandom_range(0, 15) == 0) begin
            tag = tag | ({$urandom, $urandom} << 35);
        end
        put_varint(tag, min_len);
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return 64'd0;
            1:       return 64'($urandom_range(0, 127));
            2:       return 64'($urandom_range(128, 16383));
            3:       return {$urandom, $urandom};
            4:       return '1;
            default: return 64'd1 << $urandom_range(0, 63);
        endcase
    endfunction

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 4))
            0:       return 32'($urandom_range(1, 15));
            1:       return 32'($urandom_range(16, 4095));
            2:       return 32'($urandom);
            3:       return '1;
            default: return 32'd0;
        endcase
    endfunction

    // a few fields of random kinds, sometimes corrupted or cut short
    function automatic void build_message();
        int unsigned nfields;
        int unsigned pad;
        int unsigned len;
        int unsigned keep;
        logic [31:0] fld;
        logic [2:0]  wt;
        msg_q.delete();
        nfields = $urandom_range(1, 4);
        repeat (nfields) begin
            fld = rand_field();
            pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
            case ($urandom_range(0, 15))
                0, 1, 2, 3: begin
                    put_tag(fld, pbwt_pkg::WT_VARINT, pad);
                    put_varint(rand_value(), ($urandom_range(0, 7) == 0) ? 10 : 0);
                end
                4, 5: begin
                    put_tag(fld, pbwt_pkg::WT_I32, pad);
                    repeat (4) put_byte(8'($urandom));
                end
                6, 7: begin
                    put_tag(fld, pbwt_pkg::WT_I64, pad);
                    repeat (8) put_byte(8'($urandom));
                end
                8, 9, 10, 11: begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                       : $urandom_range(0, 6);
                    put_tag(fld, pbwt_pkg::WT_LEN, pad);
                    put_varint(64'(len), ($urandom_range(0, 7) == 0) ? 3 : 0);
                    repeat (len) put_byte(8'($urandom));
                end
                12: begin
                    // unknown wire type, followed by bytes that get dropped
                    do wt = 3'($urandom); while (known_wire(wt));
                    put_tag(fld, wt, pad);
                    repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
                end
                13: begin
                    // value varint one or two groups too long
                    put_tag(fld, pbwt_pkg::WT_VARINT, pad);
                    put_varint(rand_value(), $urandom_range(11, 12));
                end
                14: begin
                    repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
                end
                default: begin
                    // overlong tag
                    put_varint(rand_value(), 11);
                end
            endcase
        end
        if ($urandom_range(0, 5) == 0) begin
            keep = $urandom_range(1, msg_q.size());
            while (msg_q.size() > keep) void'(msg_q.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // one word through the handshake; valid stays up across back-to-back words
    task automatic send_word(input logic [7:0] b, input logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= b;
        s_end_of_message <= eom;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        tokenize_byte(b, eom);
    endtask

    task automatic send_message();
        int n;
        n = msg_q.size();
        for (int i = 0; i < n; i++) begin
            send_word(msg_q[i], i == n - 1);
        end
    endtask

    // sender goes quiet until every predicted token has come out
    task automatic wait_for_tokens();
        s_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge aclk);
    endtask

    task automatic run_random_words(input int unsigned n);
        int unsigned target;
        target = words_sent + n;
        while (words_sent < target) begin
            build_message();
            send_message();
        end
    endtask

    // every non-error token kind, then the widest field and value
    task automatic test_token_kinds();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        msg_q.delete();
        put_tag(32'd1, pbwt_pkg::WT_I32, 0);
        put_byte(8'h01);
        put_byte(8'h02);
        put_byte(8'h03);
        put_byte(8'h04);
        put_tag(32'd1, pbwt_pkg::WT_I64, 0);
        put_byte(8'hff);
        put_byte(8'h00);
        put_byte(8'hff);
        put_byte(8'h00);
        put_byte(8'h80);
        put_byte(8'h7f);
        put_byte(8'h01);
        put_byte(8'hfe);
        put_tag(32'd2, pbwt_pkg::WT_LEN, 0);
        put_varint(64'd2, 0);
        put_byte(8'h00);
        put_byte(8'hff);
        // zero length on the final byte
        put_tag(32'd3, pbwt_pkg::WT_LEN, 0);
        put_varint(64'd0, 0);
        send_message();
        msg_q.delete();
        put_tag('1, pbwt_pkg::WT_VARINT, 0);
        put_varint('1, 0);
        send_message();
        wait_for_tokens();
    endtask

    // each error path, one short message apiece
    task automatic test_error_cases();
        // unknown wire type, rest of message dropped
        msg_q.delete();
        put_tag(32'd1, pbwt_pkg::WT_I64 | pbwt_pkg::WT_LEN, 0);
        put_byte(8'h00);
        put_byte(8'hff);
        send_message();
        // tag on the final byte for varint, fixed64 and fixed32 followers
        msg_q.delete();
        put_tag(32'd1, pbwt_pkg::WT_VARINT, 0);
        send_message();
        msg_q.delete();
        put_tag(32'd1, pbwt_pkg::WT_I64, 0);
        send_message();
        msg_q.delete();
        put_tag(32'd1, pbwt_pkg::WT_I32, 0);
        send_message();
        // tag varint cut off
        msg_q.delete();
        put_byte(8'h80);
        send_message();
        // nonzero length on the final byte
        msg_q.delete();
        put_tag(32'd2, pbwt_pkg::WT_LEN, 0);
        put_varint(64'd5, 0);
        send_message();
        // payload cut short
        msg_q.delete();
        put_tag(32'd2, pbwt_pkg::WT_LEN, 0);
        put_varint(64'd3, 0);
        put_byte(8'haa);
        put_byte(8'hbb);
        send_message();
        // fixed32 cut short
        msg_q.delete();
        put_tag(32'd1, pbwt_pkg::WT_I32, 0);
        put_byte(8'h11);
        send_message();
        // value varint past ten bytes, the last byte dropped
        msg_q.delete();
        put_tag(32'd1, pbwt_pkg::WT_VARINT, 0);
        put_varint(64'd0, 11);
        send_message();
        wait_for_tokens();
    endtask

    task automatic test_random_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_words(350);
        wait_for_tokens();
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 200;
        run_random_words(60);
        wait_for_tokens();
    endtask

    task automatic test_random_sender_gaps();
        send_idle_pct  = 52;
        recv_stall_pct = 0;
        run_random_words(350);
        wait_for_tokens();
    endtask

    task automatic test_random_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        run_random_words(350);
        wait_for_tokens();
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        run_random_words(350);
        wait_for_tokens();
    endtask

    // ------------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------------

    // random stalls, or a counted hold-off when one is pending
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            m_ready <= 1'b0;
            hold_off = hold_off - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // values sampled here are those from before the edge
    always @(posedge aclk) begin : check_tokens
        token_t got;
        token_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_token_kind, m_field_number, m_wire_type,
                   m_token_value, m_error_code, m_last_of_message};
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token, actual kind %0d value %h",
                         $time, got.kind, got.value);
                fail_count++;
            end else begin
                want = expected_tokens.pop_front();
                if (got !== want) begin
                    $display("%0t: token mismatch, expected kind %0d field %h wire %0d ",
                             $time, want.kind, want.field, want.wtype,
                             "value %h err %0d last %b, actual kind %0d field %h ",
                             want.value, want.err, want.eom, got.kind, got.field,
                             "wire %0d value %h err %0d last %b",
                             got.wtype, got.value, got.err, got.eom);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------

    initial begin
        clear_decoder();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_token_kinds();
        test_error_cases();
        test_random_no_idle();
        test_backpressure();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();
        wait_for_tokens();
        // keep the clock running to catch stray tokens
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/pbwt_pkg.sv
hw/rtl/protobuf_wire_tokenizer_top.sv
tb/testbench.sv
